// File: hw/rtl/mrf_pkg.sv
// Shared types, register indexes and the CRC-16/Modbus byte update for the
// Modbus RTU request framer. No dependencies.
package mrf_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SLAVE_ADDR  = 3'd0;
  localparam logic [2:0] REG_READ_FC     = 3'd1;
  localparam logic [2:0] REG_WRITE_FC    = 3'd2;
  localparam logic [2:0] REG_READ_BASE   = 3'd3;
  localparam logic [2:0] REG_WRITE_BASE  = 3'd4;

  // Command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  read_function_code;
    logic [7:0]  write_function_code;
    logic [15:0] read_base_address;
    logic [15:0] write_base_address;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] reg_offset;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
  } item_t;

  // One byte through the reflected CRC-16/Modbus register
  function automatic logic [15:0] mrf_crc_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/mrf_cfg_regs.sv
// APB-style configuration register file for the request framer.
// Depends on mrf_pkg.
module mrf_cfg_regs
  import mrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address       <= 8'd9;
      cfg.read_function_code  <= 8'd4;
      cfg.write_function_code <= 8'd16;
      cfg.read_base_address   <= 16'd2000;
      cfg.write_base_address  <= 16'd1000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SLAVE_ADDR: cfg.slave_address       <= pwdata[7:0];
        REG_READ_FC:    cfg.read_function_code  <= pwdata[7:0];
        REG_WRITE_FC:   cfg.write_function_code <= pwdata[7:0];
        REG_READ_BASE:  cfg.read_base_address   <= pwdata[15:0];
        REG_WRITE_BASE: cfg.write_base_address  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      REG_SLAVE_ADDR: prdata = {24'd0, cfg.slave_address};
      REG_READ_FC:    prdata = {24'd0, cfg.read_function_code};
      REG_WRITE_FC:   prdata = {24'd0, cfg.write_function_code};
      REG_READ_BASE:  prdata = {16'd0, cfg.read_base_address};
      REG_WRITE_BASE: prdata = {16'd0, cfg.write_base_address};
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/mrf_frame_seq.sv
// Item register, frame byte sequencer with running CRC, and output byte register.
// Depends on mrf_pkg.
module mrf_frame_seq
  import mrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      item_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic       frame_end
);

  typedef enum logic [1:0] {BK_DATA, BK_CRC_LO, BK_CRC_HI} byte_kind_t;

  localparam logic [7:0] PAD_BYTE = 8'h00;

  item_t       item;
  logic        item_valid;
  logic [3:0]  step;
  logic [15:0] crc;
  logic [7:0]  remaining;
  logic        wip;

  byte_kind_t  kind;
  logic [7:0]  hdr_byte;
  logic [7:0]  out_byte;
  logic        last;
  logic        take;
  logic        fire;
  logic [15:0] crc_next;
  logic [15:0] base;

  assign take     = !out_valid || out_ready;
  assign fire     = item_valid && take;
  assign in_ready = !item_valid || (take && last);
  assign base     = (item.command == CMD_WRITE) ? cfg.write_base_address
                                                : cfg.read_base_address;

  // Pick the byte at the current frame position
  always_comb begin
    kind     = BK_DATA;
    hdr_byte = PAD_BYTE;
    last     = 1'b0;
    if (wip) begin
      case (step)
        4'd0: begin
          hdr_byte = item.data_byte;
          last     = (remaining != 8'd1);
        end
        4'd1: kind = BK_CRC_LO;
        default: begin
          kind = BK_CRC_HI;
          last = 1'b1;
        end
      endcase
    end else begin
      case (step)
        4'd0: hdr_byte = cfg.slave_address;
        4'd1: hdr_byte = (item.command == CMD_WRITE) ? cfg.write_function_code
                                                     : cfg.read_function_code;
        4'd2: hdr_byte = base[15:8];
        4'd3: hdr_byte = base[7:0] + item.reg_offset;
        4'd4: hdr_byte = PAD_BYTE;
        4'd5: hdr_byte = {1'b0, item.byte_count[7:1]};
        4'd6: begin
          if (item.command == CMD_WRITE) begin
            hdr_byte = item.byte_count;
            last     = (item.byte_count != 8'd0);
          end else begin
            kind = BK_CRC_LO;
          end
        end
        4'd7: begin
          if (item.command == CMD_WRITE) begin
            kind = BK_CRC_LO;
          end else begin
            kind = BK_CRC_HI;
            last = 1'b1;
          end
        end
        default: begin
          kind = BK_CRC_HI;
          last = 1'b1;
        end
      endcase
    end
  end

  // CRC bytes go out as they stand; data bytes fold into the CRC
  always_comb begin
    case (kind)
      BK_CRC_LO: begin
        out_byte = crc[7:0];
        crc_next = crc;
      end
      BK_CRC_HI: begin
        out_byte = crc[15:8];
        crc_next = CRC_PRESET;
      end
      default: begin
        out_byte = hdr_byte;
        crc_next = mrf_crc_update(crc, hdr_byte);
      end
    endcase
  end

  // Item register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire && last) begin
      item_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

  // Sequencer state and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      crc       <= CRC_PRESET;
      remaining <= '0;
      wip       <= 1'b0;
    end else if (fire) begin
      step <= last ? 4'd0 : step + 4'd1;
      crc  <= crc_next;
      if (wip && step == 4'd0) begin
        remaining <= remaining - 8'd1;
      end
      if (wip && kind == BK_CRC_HI) begin
        wip <= 1'b0;
      end
      if (!wip && last && kind == BK_DATA) begin
        wip       <= 1'b1;
        remaining <= item.byte_count;
      end
    end
  end

  // Output byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      tx_byte   <= out_byte;
      frame_end <= (kind == BK_CRC_HI);
    end
  end

endmodule

// File: hw/rtl/modbus_rtu_request_framer_unit.sv
// Top level of the Modbus RTU request framer: config registers and frame sequencer.
// Depends on mrf_pkg, mrf_cfg_regs and mrf_frame_seq.

// Each input beat expands into its frame bytes, delivered one byte per clock
// through a single output byte register, with CRC-16/Modbus appended low byte
// first. A read item yields 8 bytes, a write header 7, a zero-count write 9, a
// payload byte 1 and the last payload byte 3 (byte plus CRC). The output register
// sets the pace: one byte per cycle while out_ready is high. The next input beat
// is accepted in the cycle the current item's last byte is loaded, so items run
// back to back with no idle cycle between frames. Configuration must be written
// over the APB port only while no frame is in progress; this is not enforced.
module modbus_rtu_request_framer_unit
  import mrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [7:0]         reg_offset,
  input  logic [7:0]         byte_count,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         tx_byte,
  output logic               frame_end
);

  cfg_t  cfg;
  item_t item_in;

  assign item_in = '{command:    command,
                     reg_offset: reg_offset,
                     byte_count: byte_count,
                     data_byte:  data_byte};

  mrf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrf_frame_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item_in   (item_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_byte   (tx_byte),
    .frame_end (frame_end)
  );

endmodule

// File: hw/rtl/mrf_checker.sv
// Port-level assertions for the request framer, bound to the top level.
// Depends on modbus_rtu_request_framer_unit.
module mrf_port_props (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tx_byte,
  input logic       frame_end
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(frame_end))
    else $error("output beat changed while stalled");

  // Reset leaves the output empty and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // While an item blocks the input, a byte is on the output next cycle
  a_busy_drives_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> out_valid)
    else $error("item held but no output byte produced");

  // An accepted beat shows up as output once through the item and output byte registers
  a_accept_to_out: assert property (@(posedge clk)
    (in_valid && in_ready && !rst) ##1 !rst |=> out_valid)
    else $error("accepted beat produced no output byte");

endmodule

bind modbus_rtu_request_framer_unit mrf_port_props u_mrf_port_props (.*);

// File: test/mrf_checker.sv
// Checker for the Modbus RTU request framer: watches the APB, input and output
// channels, predicts every frame byte with its CRC and compares the output beats.
// Depends on mrf_pkg.
module mrf_checker
  import mrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               command,
  input  logic [7:0]         reg_offset,
  input  logic [7:0]         byte_count,
  input  logic [7:0]         data_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         tx_byte,
  input  logic               frame_end,
  output int                 fail_count,
  output int                 pending
);

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } frame_byte_t;

  localparam cfg_t CFG_AT_RESET = '{
    slave_address:       8'd9,
    read_function_code:  8'd4,
    write_function_code: 8'd16,
    read_base_address:   16'd2000,
    write_base_address:  16'd1000
  };

  // Shadow of the block's registers and framing state
  cfg_t        cfg;
  logic [15:0] crc_acc;
  logic [7:0]  payload_left;
  logic        writing;
  frame_byte_t frame_q[$];
  int          errs = 0;

  // CRC-16/Modbus, one data bit folded in per shift
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic emit_data(input logic [7:0] b);
    crc_acc = crc16_byte(crc_acc, b);
    frame_q.push_back('{tx_byte: b, frame_end: 1'b0});
  endtask

  // CRC low byte first, high byte closes the frame
  task automatic emit_crc();
    frame_q.push_back('{tx_byte: crc_acc[7:0], frame_end: 1'b0});
    frame_q.push_back('{tx_byte: crc_acc[15:8], frame_end: 1'b1});
    crc_acc = CRC_PRESET;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] v);
    case (idx)
      REG_SLAVE_ADDR: cfg.slave_address       = v[7:0];
      REG_READ_FC:    cfg.read_function_code  = v[7:0];
      REG_WRITE_FC:   cfg.write_function_code = v[7:0];
      REG_READ_BASE:  cfg.read_base_address   = v[15:0];
      REG_WRITE_BASE: cfg.write_base_address  = v[15:0];
      default: ;
    endcase
  endtask

  // Expected frame bytes caused by one input beat
  task automatic frame_bytes(input logic cmd, input logic [7:0] off,
                             input logic [7:0] cnt, input logic [7:0] dat);
    logic [15:0] base;
    logic [7:0]  addr_lo;
    if (writing) begin
      // payload beat: only the data byte matters
      emit_data(dat);
      payload_left = payload_left - 8'd1;
      if (payload_left == 8'd0) begin
        emit_crc();
        writing = 1'b0;
      end
    end else begin
      crc_acc = CRC_PRESET;
      base    = (cmd == CMD_WRITE) ? cfg.write_base_address : cfg.read_base_address;
      addr_lo = base[7:0] + off;  // wraps, no carry into the high byte
      emit_data(cfg.slave_address);
      emit_data((cmd == CMD_WRITE) ? cfg.write_function_code : cfg.read_function_code);
      emit_data(base[15:8]);
      emit_data(addr_lo);
      emit_data(8'h00);
      emit_data({1'b0, cnt[7:1]});
      if (cmd == CMD_READ) begin
        emit_crc();
      end else begin
        emit_data(cnt);
        if (cnt == 8'd0) begin
          emit_crc();
        end else begin
          payload_left = cnt;
          writing      = 1'b1;
        end
      end
    end
  endtask

  // Compare output beats first: they always belong to earlier input beats
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      cfg          = CFG_AT_RESET;
      crc_acc      = CRC_PRESET;
      payload_left = '0;
      writing      = 1'b0;
      frame_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          if (errs < MAX_REPORTS) begin
            $error("tx_byte: expected nothing, got 0x%02h", tx_byte);
          end
          errs++;
        end else begin
          want = frame_q.pop_front();
          if (tx_byte !== want.tx_byte) begin
            if (errs < MAX_REPORTS) begin
              $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, tx_byte);
            end
            errs++;
          end
          if (frame_end !== want.frame_end) begin
            if (errs < MAX_REPORTS) begin
              $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
            end
            errs++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        write_reg(paddr[PADDR_W-1:2], pwdata);
      end
      if (in_valid && in_ready) begin
        frame_bytes(command, reg_offset, byte_count, data_byte);
      end
    end
    fail_count <= errs;
    pending    <= frame_q.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the Modbus RTU request framer: clock, reset, APB register
// writes, input beats with random gaps and output stalls. Depends on mrf_pkg,
// the framer RTL and mrf_checker.
module tb_top;
  import mrf_pkg::*;

  localparam logic [2:0] REG_UNUSED     = 3'd5;
  localparam int         STALL_PCT      = 22;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic               clk;
  logic               rst        = 1'b1;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [PDATA_W-1:0] pwdata     = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               command    = CMD_READ;
  logic [7:0]         reg_offset = '0;
  logic [7:0]         byte_count = '0;
  logic [7:0]         data_byte  = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [7:0]         tx_byte;
  logic               frame_end;
  int                 fail_count;
  int                 pending;
  int                 idle_pct     = STALL_PCT;
  int                 quiet_cycles = 0;

  modbus_rtu_request_framer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .reg_offset (reg_offset),
    .byte_count (byte_count),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .frame_end  (frame_end)
  );

  mrf_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .reg_offset (reg_offset),
    .byte_count (byte_count),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .frame_end  (frame_end),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= idle_pct);
  end

  // Watchdog: too long without any beat or register access
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input beat, with a random gap before it; without a gap valid stays up between beats
  task automatic send_item(input logic cmd, input logic [7:0] off,
                           input logic [7:0] cnt, input logic [7:0] dat);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    reg_offset <= off;
    byte_count <= cnt;
    data_byte  <= dat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Setup then access; register takes the value at the access edge
  task automatic apb_write(input logic [2:0] idx, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Whole frame: header beat, then one beat per payload byte with noise elsewhere
  task automatic send_frame(input logic cmd, input logic [7:0] off, input logic [7:0] cnt);
    send_item(cmd, off, cnt, 8'($urandom_range(255)));
    if (cmd == CMD_WRITE) begin
      for (int i = 0; i < cnt; i++) begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Random reads and writes, writes mostly short, until at least n beats have gone in
  task automatic run_frames(input int n);
    int         sent;
    int         pick;
    logic       cmd;
    logic [7:0] cnt;
    sent = 0;
    while (sent < n) begin
      cmd  = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (cmd == CMD_READ) begin
        cnt = 8'($urandom_range(255));
      end else if (pick < 15) begin
        cnt = 8'd0;
      end else if (pick < 85) begin
        cnt = 8'($urandom_range(6, 1));
      end else begin
        cnt = 8'($urandom_range(40, 7));
      end
      send_frame(cmd, 8'($urandom_range(255)), cnt);
      sent += (cmd == CMD_WRITE) ? int'(cnt) + 1 : 1;
    end
  endtask

  // Drop valid and wait for every expected byte to come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at reset configuration
    send_item(CMD_READ,  8'h00, 8'h00, 8'hFF);
    send_item(CMD_READ,  8'hFF, 8'hFF, 8'h00);
    send_item(CMD_READ,  8'h30, 8'd246, 8'h5A);  // address low byte wraps
    send_item(CMD_WRITE, 8'h18, 8'h00, 8'hFF);   // zero count, wraps too
    send_item(CMD_WRITE, 8'hFF, 8'h01, 8'h00);
    send_item(CMD_READ,  8'hFF, 8'hFF, 8'h00);   // payload beat, other fields ignored
    send_item(CMD_WRITE, 8'h00, 8'h02, 8'h77);
    send_item(CMD_WRITE, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_READ,  8'h00, 8'h00, 8'h00);
    send_item(CMD_WRITE, 8'h01, 8'h03, 8'h00);
    send_item(CMD_WRITE, 8'h00, 8'h00, 8'hA5);
    send_item(CMD_READ,  8'h80, 8'h80, 8'h5A);
    send_item(CMD_WRITE, 8'h7F, 8'h7F, 8'hC3);
    send_item(CMD_READ,  8'h7F, 8'h01, 8'h80);   // read straight after a write
    settle();

    // All registers at zero
    apb_write(REG_SLAVE_ADDR, '0);
    apb_write(REG_READ_FC, '0);
    apb_write(REG_WRITE_FC, '0);
    apb_write(REG_READ_BASE, '0);
    apb_write(REG_WRITE_BASE, '0);
    run_frames(70);
    settle();

    // All ones, upper bits must be dropped; no idling on either side
    apb_write(REG_SLAVE_ADDR, '1);
    apb_write(REG_READ_FC, '1);
    apb_write(REG_WRITE_FC, '1);
    apb_write(REG_READ_BASE, '1);
    apb_write(REG_WRITE_BASE, '1);
    idle_pct <= 0;
    run_frames(65);
    settle();
    idle_pct <= STALL_PCT;

    // Random settings, plus a write to an unmapped address
    apb_write(REG_SLAVE_ADDR, $urandom);
    apb_write(REG_READ_FC, $urandom);
    apb_write(REG_WRITE_FC, $urandom);
    apb_write(REG_READ_BASE, $urandom);
    apb_write(REG_WRITE_BASE, $urandom);
    apb_write(REG_UNUSED, $urandom);
    run_frames(70);
    settle();

    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
